// ===== src/scs_pkg.sv =====
// Shared constants and codes for the scissor clip stack.
package scs_pkg;

    // Default sizing of the stack and of stored coordinates.
    localparam int STACK_DEPTH_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;

    // Stream payload widths.
    localparam int CMD_W       = 2;
    localparam int RECT_W      = 16;
    localparam int RECT_DATA_W = 4 * RECT_W;
    localparam int OUT_DATA_W  = 72;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Configuration register widths.
    localparam int SIZE_W = 14;
    localparam int ROT_W  = 2;
    localparam int OFS_W  = 13;

    // Register reset values.
    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 14'd640;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 14'd480;
    localparam logic [SIZE_W-1:0] WINDOW_WIDTH_RST  = 14'd640;
    localparam logic [SIZE_W-1:0] WINDOW_HEIGHT_RST = 14'd480;
    localparam logic [ROT_W-1:0]  ROTATION_RST      = 2'd0;
    localparam logic [OFS_W-1:0]  OFFSET_RST        = 13'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_WINDOW_WIDTH  = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_ROTATION      = 3'd4,
        CFG_OFFSET_X      = 3'd5,
        CFG_OFFSET_Y      = 3'd6
    } cfg_idx_t;

    // Commands carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // Result error codes.
    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } err_t;

    // Quarter-turn rotation codes.
    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

endpackage

// ===== src/scissor_clip_stack.sv =====
// Scissor rectangle stack with push clipping, pop and visibility query.
//
//  Channel   | Direction | Handshake                   | Payload
//  ----------+-----------+-----------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser command, tdata rectangle
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata scissor state and status
//  cfg       | in        | cfg_we                      | cfg_index, cfg_data
//
// One command is taken per cycle unless the output stalls; each result passes the input
// register, then the result register, and is set by the single compute stage between them.
// The top stack entry lives in a register and the entry below it is prefetched from the
// stack memory every cycle, so back-to-back pops and pushes need no stall.
// Reset empties the stack at once; the memory needs no clearing pass.
// A result that is not taken holds the result register, then the input register, and
// only then drops s_axis_tready.
module scissor_clip_stack #(
    parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF,
    parameter int COORD_BITS  = scs_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h (16 bits each)
    input  logic [scs_pkg::RECT_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic [scs_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // scissor_enable, scissor_x, scissor_y, scissor_w, scissor_h, visible,
    // error_code, then zero fill
    output logic [scs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import scs_pkg::*;

    // Sizing derived from the parameters.
    localparam int C     = COORD_BITS;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int WW    = ((COORD_BITS > 20) ? COORD_BITS : 20) + 4;

    // Layout of one stack entry: clipped box, then the box as requested.
    localparam int CX_LSB = 0;
    localparam int CY_LSB = C;
    localparam int CW_LSB = 2 * C;
    localparam int CH_LSB = 3 * C - 1;
    localparam int RX_LSB = 4 * C - 2;
    localparam int RY_LSB = RX_LSB + RECT_W;
    localparam int RW_LSB = RY_LSB + RECT_W;
    localparam int RH_LSB = RW_LSB + RECT_W;
    localparam int EW     = RH_LSB + RECT_W;

    typedef logic signed [WW-1:0] wide_t;
    typedef logic [EW-1:0]        entry_t;

    // Saturation limits for stored and reported values.
    localparam wide_t C_HI = {{(WW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam wide_t C_LO = ~C_HI;
    localparam wide_t S_HI = {{(WW-15){1'b0}}, {15{1'b1}}};
    localparam wide_t S_LO = ~S_HI;
    localparam wide_t ZERO = '0;

    localparam logic [CNT_W-1:0] CNT_ONE  = {{(CNT_W-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_ONE + CNT_ONE;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    function automatic wide_t sx16(input logic [RECT_W-1:0] v);
        sx16 = {{(WW-RECT_W){v[RECT_W-1]}}, v};
    endfunction

    function automatic wide_t zx_size(input logic [SIZE_W-1:0] v);
        zx_size = {{(WW-SIZE_W){1'b0}}, v};
    endfunction

    function automatic wide_t sx_ofs(input logic [OFS_W-1:0] v);
        sx_ofs = {{(WW-OFS_W){v[OFS_W-1]}}, v};
    endfunction

    function automatic wide_t sx_coord(input logic [C-1:0] v);
        sx_coord = {{(WW-C){v[C-1]}}, v};
    endfunction

    function automatic wide_t zx_len(input logic [C-2:0] v);
        zx_len = {{(WW-C+1){1'b0}}, v};
    endfunction

    function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
        if (v < lo) begin
            clamp = lo;
        end
        else if (v > hi) begin
            clamp = hi;
        end
        else begin
            clamp = v;
        end
    endfunction

    // Configuration registers.
    logic [SIZE_W-1:0] screen_width_reg;
    logic [SIZE_W-1:0] screen_height_reg;
    logic [SIZE_W-1:0] window_width_reg;
    logic [SIZE_W-1:0] window_height_reg;
    logic [ROT_W-1:0]  rotation_reg;
    logic [OFS_W-1:0]  offset_x_reg;
    logic [OFS_W-1:0]  offset_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
            rotation_reg      <= ROTATION_RST;
            offset_x_reg      <= OFFSET_RST;
            offset_y_reg      <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_ROTATION:      rotation_reg      <= cfg_data[ROT_W-1:0];
                CFG_OFFSET_X:      offset_x_reg      <= cfg_data[OFS_W-1:0];
                CFG_OFFSET_Y:      offset_y_reg      <= cfg_data[OFS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input register and flow control.
    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [RECT_W-1:0]   in_x_reg;
    logic [RECT_W-1:0]   in_y_reg;
    logic [RECT_W-1:0]   in_w_reg;
    logic [RECT_W-1:0]   in_h_reg;
    logic                out_valid_reg;
    logic                advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg <= s_axis_tuser;
            in_x_reg   <= s_axis_tdata[0 +: RECT_W];
            in_y_reg   <= s_axis_tdata[RECT_W +: RECT_W];
            in_w_reg   <= s_axis_tdata[2*RECT_W +: RECT_W];
            in_h_reg   <= s_axis_tdata[3*RECT_W +: RECT_W];
        end
    end

    // Stack state: fill count, cached top entry and the prefetched entry below it.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           top_reg;
    entry_t           top_next;
    entry_t           below_reg;
    entry_t           new_entry;
    entry_t           stack_mem [STACK_DEPTH];
    logic [CNT_W-1:0] below_cnt;
    logic [AW-1:0]    below_addr;
    logic [AW-1:0]    wr_addr;
    logic             push_do;
    logic             pop_do;
    logic             stack_full;
    logic             stack_empty;

    assign stack_full  = (count_reg >= CNT_FULL);
    assign stack_empty = (count_reg == '0);
    assign wr_addr     = count_reg[AW-1:0];
    assign below_cnt   = count_next - CNT_TWO;
    assign below_addr  = below_cnt[AW-1:0];

    // Top entry fields widened for arithmetic.
    wide_t t_x, t_y, t_w, t_h;
    wide_t r_x, r_y, r_w, r_h;

    assign t_x = sx_coord(top_reg[CX_LSB +: C]);
    assign t_y = sx_coord(top_reg[CY_LSB +: C]);
    assign t_w = zx_len(top_reg[CW_LSB +: C-1]);
    assign t_h = zx_len(top_reg[CH_LSB +: C-1]);
    assign r_x = sx16(top_reg[RX_LSB +: RECT_W]);
    assign r_y = sx16(top_reg[RY_LSB +: RECT_W]);
    assign r_w = sx16(top_reg[RW_LSB +: RECT_W]);
    assign r_h = sx16(top_reg[RH_LSB +: RECT_W]);

    // Request and configuration values widened.
    wide_t q_x, q_y, q_w, q_h;
    wide_t scr_w, scr_h, win_w, win_h, ofs_x, ofs_y;

    assign q_x   = sx16(in_x_reg);
    assign q_y   = sx16(in_y_reg);
    assign q_w   = sx16(in_w_reg);
    assign q_h   = sx16(in_h_reg);
    assign scr_w = zx_size(screen_width_reg);
    assign scr_h = zx_size(screen_height_reg);
    assign win_w = zx_size(window_width_reg);
    assign win_h = zx_size(window_height_reg);
    assign ofs_x = sx_ofs(offset_x_reg);
    assign ofs_y = sx_ofs(offset_y_reg);

    // Push: fill zero sizes, rotate into window space, clip against the top, saturate.
    wide_t b_w, b_h, m_x, m_y, m_w, m_h;
    wide_t c_x, c_y, c_w, c_h, t_r, t_t;
    wide_t n_x, n_y, n_w, n_h;

    always_comb
    begin
        b_w = (q_w == ZERO) ? (scr_w - q_x) : q_w;
        b_h = (q_h == ZERO) ? (scr_h - q_y) : q_h;

        case (rot_t'(rotation_reg))
            ROT_0:
            begin
                m_x = q_x + ofs_x;
                m_y = win_h - (q_y + b_h) - ofs_y;
                m_w = b_w;
                m_h = b_h;
            end
            ROT_90:
            begin
                m_x = scr_h - (q_y + b_h) + ofs_y;
                m_y = win_w - (q_x + b_w) - ofs_x;
                m_w = b_h;
                m_h = b_w;
            end
            ROT_180:
            begin
                m_x = scr_w - (q_x + b_w) + ofs_x;
                m_y = win_h - scr_h + q_y - ofs_y;
                m_w = b_w;
                m_h = b_h;
            end
            default:
            begin
                m_x = q_y + ofs_y;
                m_y = win_w - scr_w + q_x - ofs_x;
                m_w = b_h;
                m_h = b_w;
            end
        endcase

        // Intersect with the current top when there is one.
        t_r = t_x + t_w;
        t_t = t_y + t_h;
        c_x = m_x;
        c_y = m_y;
        c_w = m_w;
        c_h = m_h;
        if (!stack_empty)
        begin
            c_x = (t_x > m_x) ? t_x : m_x;
            c_y = (t_y > m_y) ? t_y : m_y;
            if (t_r < c_x + m_w)
            begin
                c_w = t_r - c_x;
            end
            if (t_t < c_y + m_h)
            begin
                c_h = t_t - c_y;
            end
        end

        n_x = clamp(c_x, C_LO, C_HI);
        n_y = clamp(c_y, C_LO, C_HI);
        n_w = clamp(c_w, ZERO, C_HI);
        n_h = clamp(c_h, ZERO, C_HI);

        new_entry = {in_h_reg, in_w_reg, in_y_reg, in_x_reg,
                     n_h[C-2:0], n_w[C-2:0], n_y[C-1:0], n_x[C-1:0]};
    end

    // Query: inclusive overlap against the window and the requested top box.
    logic vis_calc;
    logic q_left_out, q_below_out, q_on_edge, win_ov, req_ov;
    wide_t q_r, q_t;

    always_comb
    begin
        q_r         = q_x + q_w;
        q_t         = q_y + q_h;
        q_left_out  = (q_w > ZERO) && (q_r <= ZERO);
        q_below_out = (q_h > ZERO) && (q_t <= ZERO);
        q_on_edge   = (q_x == win_w) || (q_y == win_h);
        win_ov      = (((ZERO >= q_x) && (ZERO <= q_r)) || ((q_x >= ZERO) && (q_x <= win_w)))
                   && (((ZERO >= q_y) && (ZERO <= q_t)) || ((q_y >= ZERO) && (q_y <= win_h)));
        req_ov      = (((r_x >= q_x) && (r_x <= q_r)) || ((q_x >= r_x) && (q_x <= r_x + r_w)))
                   && (((r_y >= q_y) && (r_y <= q_t)) || ((q_y >= r_y) && (q_y <= r_y + r_h)));
        vis_calc    = !q_left_out && !q_below_out && !q_on_edge && win_ov
                   && (stack_empty || req_ov);
    end

    // Command decode.
    logic       vis_next;
    logic [1:0] err_next;

    always_comb
    begin
        push_do  = 1'b0;
        pop_do   = 1'b0;
        vis_next = 1'b0;
        err_next = ERR_OK;
        unique case (cmd_t'(in_cmd_reg))
            CMD_PUSH:
            begin
                if (stack_full)
                begin
                    err_next = ERR_OVERFLOW;
                end
                else
                begin
                    push_do = advance;
                end
            end
            CMD_POP:
            begin
                if (stack_empty)
                begin
                    err_next = ERR_UNDERFLOW;
                end
                else
                begin
                    pop_do = advance;
                end
            end
            CMD_QUERY: vis_next = vis_calc;
            default:   ;
        endcase

        count_next = count_reg;
        top_next   = top_reg;
        if (push_do)
        begin
            count_next = count_reg + CNT_ONE;
            top_next   = new_entry;
        end
        else if (pop_do)
        begin
            count_next = count_reg - CNT_ONE;
            top_next   = below_reg;
        end
    end

    // Count update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Top register, stack memory and prefetch of the entry below the top.
    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        below_reg <= stack_mem[below_addr];
        if (push_do)
        begin
            stack_mem[wr_addr] <= new_entry;
        end
    end

    // Result fields from the top after this step.
    logic        en_next;
    wide_t       o_x, o_y, o_w, o_h;

    assign en_next = (count_next != '0);
    assign o_x     = clamp(sx_coord(top_next[CX_LSB +: C]), S_LO, S_HI);
    assign o_y     = clamp(sx_coord(top_next[CY_LSB +: C]), S_LO, S_HI);
    assign o_w     = clamp(zx_len(top_next[CW_LSB +: C-1]), ZERO, S_HI);
    assign o_h     = clamp(zx_len(top_next[CH_LSB +: C-1]), ZERO, S_HI);

    // Result register.
    logic        out_en_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [14:0] out_w_reg;
    logic [14:0] out_h_reg;
    logic        out_vis_reg;
    logic [1:0]  out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_en_reg  <= en_next;
            out_x_reg   <= en_next ? o_x[15:0] : 16'd0;
            out_y_reg   <= en_next ? o_y[15:0] : 16'd0;
            out_w_reg   <= en_next ? o_w[14:0] : 15'd0;
            out_h_reg   <= en_next ? o_h[14:0] : 15'd0;
            out_vis_reg <= vis_next;
            out_err_reg <= err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_err_reg, out_vis_reg, out_h_reg, out_w_reg,
                            out_y_reg, out_x_reg, out_en_reg};

endmodule
